// File: rtl/mobis_pkg.sv
// Shared types and constants for the meter value extractor.
// Used by the front parser, the item queue, the back scaler and the top level.
// Depends on nothing.
`default_nettype none

package mobis_pkg;

	// Header bytes that open a record.
	localparam logic [7:0] HDR_FIRST  = 8'd9;
	localparam logic [7:0] HDR_SECOND = 8'd6;
	localparam logic [7:0] HDR_ONE    = 8'd1;

	// Power subtype bytes.
	localparam logic [7:0] SUB_INSTANT = 8'd7;
	localparam logic [7:0] SUB_CUMUL   = 8'd8;

	// Group bytes for the power groups and the phase channels.
	localparam logic [7:0] GRP_POWER_LO = 8'd1;
	localparam logic [7:0] GRP_POWER_HI = 8'd4;
	localparam logic [7:0] GRP_AMP1     = 8'd31;
	localparam logic [7:0] GRP_AMP2     = 8'd51;
	localparam logic [7:0] GRP_AMP3     = 8'd71;
	localparam logic [7:0] GRP_VOL1     = 8'd32;
	localparam logic [7:0] GRP_VOL2     = 8'd52;
	localparam logic [7:0] GRP_VOL3     = 8'd72;

	// Quantity codes.
	localparam logic [3:0] QTY_AMP1 = 4'd8;
	localparam logic [3:0] QTY_AMP2 = 4'd9;
	localparam logic [3:0] QTY_AMP3 = 4'd10;
	localparam logic [3:0] QTY_VOL1 = 4'd11;
	localparam logic [3:0] QTY_VOL2 = 4'd12;
	localparam logic [3:0] QTY_VOL3 = 4'd13;
	localparam logic [3:0] QTY_FIRST_PHASE = 4'd8;

	// Bytes skipped before the value, per record kind.
	localparam logic [2:0] SKIP_POWER = 3'd5;
	localparam logic [2:0] SKIP_AMP   = 3'd6;
	localparam logic [2:0] SKIP_VOL   = 3'd4;

	// Division by 100 as a multiplication by a reciprocal; exact for all 16-bit inputs.
	localparam int unsigned  DIV100_SHIFT = 23;
	localparam logic [16:0]  DIV100_MULT  = 17'd83887;

	// One parsed reading between the front and the back.
	typedef struct packed {
		logic [3:0]  quantity;
		logic [15:0] raw;
	} mobis_item_t;

endpackage

`default_nettype wire

// File: rtl/mobis_front.sv
// Front parser: walks the byte stream, matches the record header and group,
// and hands each finished raw reading to the item queue. Uses mobis_pkg.
`default_nettype none

module mobis_front
	import mobis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	input  wire logic [7:0]  byte_data,
	output logic             item_valid,
	output mobis_item_t      item
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GOT9,
		ST_GOT96,
		ST_GOT961,
		ST_GROUP,
		ST_SUBTYPE,
		ST_SKIP,
		ST_HIGH,
		ST_LOW
	} state_t;

	state_t      state_q;
	logic [1:0]  group_q;
	logic [3:0]  qty_q;
	logic [2:0]  skip_q;
	logic [7:0]  high_q;

	// A reading is complete when the low value byte arrives.
	assign item_valid    = byte_valid && (state_q == ST_LOW);
	assign item.quantity = qty_q;
	assign item.raw      = {high_q, byte_data};

	// Parser state and the fields gathered along the record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			group_q <= '0;
			qty_q   <= '0;
			skip_q  <= '0;
			high_q  <= '0;
		end else if (byte_valid) begin
			case (state_q)
				ST_IDLE: begin
					state_q <= (byte_data == HDR_FIRST) ? ST_GOT9 : ST_IDLE;
				end
				ST_GOT9: begin
					state_q <= (byte_data == HDR_SECOND) ? ST_GOT96 : ST_IDLE;
				end
				ST_GOT96: begin
					state_q <= (byte_data == HDR_ONE) ? ST_GOT961 : ST_IDLE;
				end
				ST_GOT961: begin
					state_q <= (byte_data == HDR_ONE) ? ST_GROUP : ST_IDLE;
				end
				ST_GROUP: begin
					if (byte_data inside {[GRP_POWER_LO:GRP_POWER_HI]}) begin
						group_q <= 2'(byte_data - GRP_POWER_LO);
						state_q <= ST_SUBTYPE;
					end else begin
						case (byte_data)
							GRP_AMP1: begin
								qty_q   <= QTY_AMP1;
								skip_q  <= SKIP_AMP;
								state_q <= ST_SKIP;
							end
							GRP_AMP2: begin
								qty_q   <= QTY_AMP2;
								skip_q  <= SKIP_AMP;
								state_q <= ST_SKIP;
							end
							GRP_AMP3: begin
								qty_q   <= QTY_AMP3;
								skip_q  <= SKIP_AMP;
								state_q <= ST_SKIP;
							end
							GRP_VOL1: begin
								qty_q   <= QTY_VOL1;
								skip_q  <= SKIP_VOL;
								state_q <= ST_SKIP;
							end
							GRP_VOL2: begin
								qty_q   <= QTY_VOL2;
								skip_q  <= SKIP_VOL;
								state_q <= ST_SKIP;
							end
							GRP_VOL3: begin
								qty_q   <= QTY_VOL3;
								skip_q  <= SKIP_VOL;
								state_q <= ST_SKIP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SUBTYPE: begin
					if (byte_data == SUB_INSTANT || byte_data == SUB_CUMUL) begin
						qty_q   <= {1'b0, group_q, (byte_data == SUB_CUMUL)};
						skip_q  <= SKIP_POWER;
						state_q <= ST_SKIP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SKIP: begin
					// The byte at a count of one or less is the last one ignored.
					if (skip_q <= 3'd1) begin
						skip_q  <= '0;
						state_q <= ST_HIGH;
					end else begin
						skip_q <= skip_q - 3'd1;
					end
				end
				ST_HIGH: begin
					high_q  <= byte_data;
					state_q <= ST_LOW;
				end
				ST_LOW: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/mobis_queue.sv
// Short flip-flop queue of parsed readings between the front and the back.
// Uses mobis_pkg for the item type.
`default_nettype none

module mobis_queue
	import mobis_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  mobis_item_t      wr_item,
	output logic             full,
	input  wire logic        rd_en,
	output mobis_item_t      rd_item,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mobis_item_t   slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/mobis_back.sv
// Back scaler: takes readings from the queue, applies the scale for the
// quantity and holds the result in an output register. Uses mobis_pkg.
`default_nettype none

module mobis_back
	import mobis_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_empty,
	input  mobis_item_t      src_item,
	output logic             src_pop,
	input  wire logic        pop,
	output logic             empty,
	output logic [3:0]       quantity,
	output logic [19:0]      value
);

	logic        valid_q;
	logic [3:0]  qty_q;
	logic [19:0] value_q;

	logic [32:0] recip_prod;
	logic [19:0] times_ten;
	logic [19:0] scaled;

	// Load a new reading when the output register is free or being drained.
	assign src_pop = !src_empty && (!valid_q || pop);

	// Scale: cumulative power times ten, currents divided by 100, rest as is.
	assign recip_prod = {17'd0, src_item.raw} * {16'd0, DIV100_MULT};
	assign times_ten  = {1'b0, src_item.raw, 3'b000} + {3'b000, src_item.raw, 1'b0};

	always_comb begin
		scaled = {4'd0, src_item.raw};
		if (src_item.quantity < QTY_FIRST_PHASE && src_item.quantity[0]) begin
			scaled = times_ten;
		end else if (src_item.quantity inside {[QTY_AMP1:QTY_AMP3]}) begin
			scaled = {10'd0, recip_prod[DIV100_SHIFT +: 10]};
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (src_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (src_pop) begin
			qty_q   <= src_item.quantity;
			value_q <= scaled;
		end
	end

	assign empty    = !valid_q;
	assign quantity = qty_q;
	assign value    = value_q;

endmodule

`default_nettype wire

// File: rtl/meter_obis_value_extractor.sv
// Top level of the meter value extractor: front parser, item queue, back scaler.
// Depends on mobis_pkg, mobis_front, mobis_queue and mobis_back.
//
//   Channel   Handshake          Payload
//   input     push / full        data_byte[7:0]
//   result    empty / pop        quantity[3:0], value[19:0]
//
// One byte is taken per cycle while full is low; the parser advances one step a byte.
// A reading reaches the result ports through the queue and then the scaler's output register:
// the queue is written at the edge that takes its low value byte, and the output register loads
// once it is free or being drained (the reciprocal multiply for currents sits in front of it).
// full rises only when the queue is full, which takes a stalled result side and several
// records; a waiting result does not stop input.
// Reset clears the parser state, the queue and the output valid flag at once.
`default_nettype none

module meter_obis_value_extractor
	import mobis_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       quantity,
	output logic [19:0]      value
);

	logic        byte_valid;
	logic        item_valid;
	mobis_item_t front_item;
	mobis_item_t queue_item;
	logic        queue_empty;
	logic        queue_pop;

	// A byte beat is taken whenever the queue has room.
	assign byte_valid = push && !full;

	mobis_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (data_byte),
		.item_valid (item_valid),
		.item       (front_item)
	);

	mobis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (item_valid),
		.wr_item (front_item),
		.full    (full),
		.rd_en   (queue_pop),
		.rd_item (queue_item),
		.empty   (queue_empty)
	);

	mobis_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_empty (queue_empty),
		.src_item  (queue_item),
		.src_pop   (queue_pop),
		.pop       (pop),
		.empty     (empty),
		.quantity  (quantity),
		.value     (value)
	);

endmodule

`default_nettype wire
